// ----- design/ifc_pkg.sv -----
// Shared types, constants and row-order tables for the interlaced frame compositor.
// No dependencies; the configuration, raster, remap, output-stage and top-level files import this package.
package ifc_pkg;

  // Default depth of the palette remap table
  localparam int unsigned MAP_ENTRIES_DEF = 256;

  localparam int unsigned DIM_W     = 16;
  localparam int unsigned IDX8_W    = 8;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CANVAS_WIDTH       = 3'd0,
    CFG_FRAME_LEFT         = 3'd1,
    CFG_FRAME_TOP          = 3'd2,
    CFG_FRAME_COLS         = 3'd3,
    CFG_FRAME_ROWS         = 3'd4,
    CFG_TRANSPARENT_ENABLE = 3'd5,
    CFG_TRANSPARENT_INDEX  = 3'd6,
    CFG_INTERLACED         = 3'd7
  } cfg_idx_e;

  // Current configuration as seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0]  canvas_width;
    logic [DIM_W-1:0]  frame_left;
    logic [DIM_W-1:0]  frame_top;
    logic [DIM_W-1:0]  frame_cols;
    logic [DIM_W-1:0]  frame_rows;
    logic              transparent_enable;
    logic [IDX8_W-1:0] transparent_index;
    logic              interlaced;
  } cfg_t;

  // Position of the pixel being accepted, from the raster tracker
  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             last;
  } pos_t;

  // First pipeline stage payload
  typedef struct packed {
    logic [DIM_W:0] row_sum;
    logic [DIM_W:0] col_sum;
    logic           we;
    logic           last;
  } s1_t;

  // Interlaced pass start rows: 0, 4, 2, 1
  function automatic logic [DIM_W-1:0] pass_start(input logic [1:0] pass);
    logic [DIM_W-1:0] r;
    unique case (pass)
      2'd0:    r = DIM_W'(0);
      2'd1:    r = DIM_W'(4);
      2'd2:    r = DIM_W'(2);
      default: r = DIM_W'(1);
    endcase
    return r;
  endfunction

  // Interlaced pass row steps: 8, 8, 4, 2
  function automatic logic [DIM_W-1:0] pass_step(input logic [1:0] pass);
    logic [DIM_W-1:0] r;
    unique case (pass)
      2'd0:    r = DIM_W'(8);
      2'd1:    r = DIM_W'(8);
      2'd2:    r = DIM_W'(4);
      default: r = DIM_W'(2);
    endcase
    return r;
  endfunction

endpackage

// ----- design/ifc_pix_if.sv -----
// Input channel of the compositor: remap loads and frame pixels.
// Valid/ready handshake; no package dependency.
interface ifc_pix_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] map_slot;
  logic [7:0] map_target;
  logic [7:0] source_index;
  logic       frame_begin;

  modport source (
    output valid, func, map_slot, map_target, source_index, frame_begin,
    input  ready
  );
  modport sink (
    input  valid, func, map_slot, map_target, source_index, frame_begin,
    output ready
  );
endinterface

// ----- design/ifc_res_if.sv -----
// Result channel of the compositor: canvas write beats.
// Valid/ready handshake; no package dependency.
interface ifc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] canvas_address;
  logic        write_enable;
  logic [7:0]  pixel_value;
  logic        frame_end;

  modport source (
    output valid, canvas_address, write_enable, pixel_value, frame_end,
    input  ready
  );
  modport sink (
    input  valid, canvas_address, write_enable, pixel_value, frame_end,
    output ready
  );
endinterface

// ----- design/ifc_cfg_regs.sv -----
// Configuration register file of the compositor, written through a plain write port.
// Depends on ifc_pkg.
module ifc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ifc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ifc_pkg::CFG_W-1:0]     cfg_data_i,
  output ifc_pkg::cfg_t                 cfg_o
);
  import ifc_pkg::*;

  cfg_t cfg_q;

  // Write the addressed register; reset to the documented defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{canvas_width: DIM_W'(1), frame_cols: DIM_W'(1), frame_rows: DIM_W'(1),
                 default: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CANVAS_WIDTH:       cfg_q.canvas_width       <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_LEFT:         cfg_q.frame_left         <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_TOP:          cfg_q.frame_top          <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_COLS:         cfg_q.frame_cols         <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_ROWS:         cfg_q.frame_rows         <= cfg_data_i[DIM_W-1:0];
        CFG_TRANSPARENT_ENABLE: cfg_q.transparent_enable <= cfg_data_i[0];
        CFG_TRANSPARENT_INDEX:  cfg_q.transparent_index  <= cfg_data_i[IDX8_W-1:0];
        CFG_INTERLACED:         cfg_q.interlaced         <= cfg_data_i[0];
        default:                cfg_q                    <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/ifc_raster.sv -----
// Raster position tracker: column, row, completed rows and interlace pass.
// Depends on ifc_pkg (cfg_t, pos_t, pass tables).
module ifc_raster (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ifc_pkg::cfg_t cfg_i,
  input  logic          pix_acc_i,
  input  logic          frame_begin_i,
  output ifc_pkg::pos_t pos_o
);
  import ifc_pkg::*;

  logic [DIM_W-1:0] col_q, col_d;
  logic [DIM_W-1:0] done_q, done_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic [1:0]       pass_q, pass_d;

  logic [DIM_W-1:0] col_e, done_e, row_e;
  logic [1:0]       pass_e;
  logic             col_last, row_last;
  logic [DIM_W-1:0] nrow;
  logic [1:0]       npass;

  // Restart the position on the first pixel of a frame
  always_comb begin
    col_e  = frame_begin_i ? '0 : col_q;
    done_e = frame_begin_i ? '0 : done_q;
    row_e  = frame_begin_i ? '0 : row_q;
    pass_e = frame_begin_i ? '0 : pass_q;
  end

  assign col_last = ({1'b0, col_e} + 17'd1)  >= {1'b0, cfg_i.frame_cols};
  assign row_last = ({1'b0, done_e} + 17'd1) >= {1'b0, cfg_i.frame_rows};

  // Next row: plain increment, or step within the pass and fall to the next pass
  always_comb begin
    logic [DIM_W:0] sum;
    sum   = {1'b0, row_e} + {1'b0, pass_step(pass_e)};
    nrow  = '0;
    npass = '0;
    if (!cfg_i.interlaced) begin
      nrow  = row_e + DIM_W'(1);
      npass = pass_e;
    end else if (sum < {1'b0, cfg_i.frame_rows}) begin
      nrow  = sum[DIM_W-1:0];
      npass = pass_e;
    end else begin
      // Take the earliest later pass whose start row lies inside the frame
      for (int p = 3; p >= 1; p--) begin
        if (2'(p) > pass_e && pass_start(2'(p)) < cfg_i.frame_rows) begin
          nrow  = pass_start(2'(p));
          npass = 2'(p);
        end
      end
    end
  end

  // Advance the position by one pixel
  always_comb begin
    col_d  = col_e + DIM_W'(1);
    done_d = done_e;
    row_d  = row_e;
    pass_d = pass_e;
    if (col_last) begin
      if (row_last) begin
        col_d  = '0;
        done_d = '0;
        row_d  = '0;
        pass_d = '0;
      end else begin
        col_d  = '0;
        done_d = done_e + DIM_W'(1);
        row_d  = nrow;
        pass_d = npass;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      done_q <= '0;
      row_q  <= '0;
      pass_q <= '0;
    end else if (pix_acc_i) begin
      col_q  <= col_d;
      done_q <= done_d;
      row_q  <= row_d;
      pass_q <= pass_d;
    end
  end

  assign pos_o.row  = row_e;
  assign pos_o.col  = col_e;
  assign pos_o.last = col_last & row_last;

endmodule

// ----- design/ifc_remap.sv -----
// Palette remap table: one write port for load beats, one registered read for pixels.
// Depends on ifc_pkg.
module ifc_remap #(
  parameter int unsigned MAP_ENTRIES = ifc_pkg::MAP_ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [ifc_pkg::IDX8_W-1:0] wr_slot_i,
  input  logic [ifc_pkg::IDX8_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [ifc_pkg::IDX8_W-1:0] rd_idx_i,
  output logic [ifc_pkg::IDX8_W-1:0] rd_data_o,
  output logic                       rd_hit_o
);
  import ifc_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAP_ENTRIES);

  logic [IDX8_W-1:0] mem [MAP_ENTRIES];
  logic [IDX8_W-1:0] rd_data_q;
  logic              rd_hit_q;
  logic              wr_hit, rd_hit;

  assign wr_hit = {1'b0, wr_slot_i} < (IDX8_W + 1)'(MAP_ENTRIES);
  assign rd_hit = {1'b0, rd_idx_i}  < (IDX8_W + 1)'(MAP_ENTRIES);

  // Write a load beat; drop slots beyond the table
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_hit) begin
      mem[wr_slot_i[IDX_W-1:0]] <= wr_data_i;
    end
  end

  // Read for an accepted pixel; hold while the pipeline stalls
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i[IDX_W-1:0]];
      rd_hit_q  <= rd_hit;
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_hit_o  = rd_hit_q;

endmodule

// ----- design/ifc_out_stage.sv -----
// Result stage: row times stride plus column, remapped value, into the output register.
// Depends on ifc_pkg (s1_t).
module ifc_out_stage (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  ifc_pkg::s1_t               s1_i,
  input  logic [ifc_pkg::DIM_W-1:0]  canvas_width_i,
  input  logic [ifc_pkg::IDX8_W-1:0] map_data_i,
  input  logic                       map_hit_i,
  output logic [ifc_pkg::ADDR_W-1:0] addr_o,
  output logic                       we_o,
  output logic [ifc_pkg::IDX8_W-1:0] val_o,
  output logic                       last_o
);
  import ifc_pkg::*;

  logic [ADDR_W:0]   prod;
  logic [ADDR_W-1:0] addr_d, addr_q;
  logic [IDX8_W-1:0] val_d, val_q;
  logic              we_q, last_q;

  // Address wraps to 32 bits
  assign prod   = (ADDR_W + 1)'(s1_i.row_sum) * (ADDR_W + 1)'(canvas_width_i);
  assign addr_d = prod[ADDR_W-1:0] + ADDR_W'(s1_i.col_sum);
  assign val_d  = (s1_i.we && map_hit_i) ? map_data_i : '0;

  // Load the result beat when the output register frees up
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      addr_q <= addr_d;
      we_q   <= s1_i.we;
      val_q  <= val_d;
      last_q <= s1_i.last;
    end
  end

  assign addr_o = addr_q;
  assign we_o   = we_q;
  assign val_o  = val_q;
  assign last_o = last_q;

endmodule

// ----- design/interlaced_frame_compositor.sv -----
// Top level of the interlaced frame compositor: handshake, stage registers, submodules.
// Depends on ifc_pkg, ifc_pix_if, ifc_res_if and the ifc_* submodules.
//
//  channel   | dir | handshake      | beat contents
//  pix_i     | in  | valid / ready  | func, map_slot, map_target, source_index, frame_begin
//  res_o     | out | valid / ready  | canvas_address, write_enable, pixel_value, frame_end
//  cfg       | in  | cfg_we_i       | cfg_idx_i, cfg_data_i
//
// One beat is accepted per cycle while the input is ready. A pixel beat is
// registered in the first stage with its position and remap read, and the 17x16
// address multiply and add fill the second. Load beats give no result.
// Two stage registers absorb a stalled output, so input stays ready until both hold a beat.
// Reset clears the control and position state; the remap table has no reset.
module interlaced_frame_compositor #(
  parameter int unsigned MAP_ENTRIES = ifc_pkg::MAP_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ifc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ifc_pkg::CFG_W-1:0]     cfg_data_i,
  ifc_pix_if.sink                       pix_i,
  ifc_res_if.source                     res_o
);
  import ifc_pkg::*;

  cfg_t cfg;
  pos_t pos;
  s1_t  s1_d, s1_q;

  logic              s1_valid_q, s1_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              out_adv, in_ready, in_acc, pix_acc, load_acc;
  logic [IDX8_W-1:0] map_data;
  logic              map_hit;

  // Handshake: the output register frees when empty or taken
  assign out_adv  = !out_valid_q || res_o.ready;
  assign in_ready = !s1_valid_q || out_adv;
  assign in_acc   = pix_i.valid && in_ready;
  assign pix_acc  = in_acc && pix_i.func;
  assign load_acc = in_acc && !pix_i.func;

  assign s1_valid_d  = in_ready ? pix_acc : s1_valid_q;
  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  ifc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ifc_raster u_raster (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .pix_acc_i     (pix_acc),
    .frame_begin_i (pix_i.frame_begin),
    .pos_o         (pos)
  );

  ifc_remap #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_remap (
    .clk_i     (clk_i),
    .wr_en_i   (load_acc),
    .wr_slot_i (pix_i.map_slot),
    .wr_data_i (pix_i.map_target),
    .rd_en_i   (pix_acc),
    .rd_idx_i  (pix_i.source_index),
    .rd_data_o (map_data),
    .rd_hit_o  (map_hit)
  );

  // First stage: offset position, transparency test
  always_comb begin
    s1_d.row_sum = {1'b0, cfg.frame_top} + {1'b0, pos.row};
    s1_d.col_sum = {1'b0, cfg.frame_left} + {1'b0, pos.col};
    s1_d.we      = !(cfg.transparent_enable &&
                     (pix_i.source_index == cfg.transparent_index));
    s1_d.last    = pos.last;
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_q <= s1_d;
    end
  end

  ifc_out_stage u_out (
    .clk_i          (clk_i),
    .load_i         (out_adv && s1_valid_q),
    .s1_i           (s1_q),
    .canvas_width_i (cfg.canvas_width),
    .map_data_i     (map_data),
    .map_hit_i      (map_hit),
    .addr_o         (res_o.canvas_address),
    .we_o           (res_o.write_enable),
    .val_o          (res_o.pixel_value),
    .last_o         (res_o.frame_end)
  );

  assign pix_i.ready = in_ready;
  assign res_o.valid = out_valid_q;

endmodule

// ----- design/ifc_checker.sv -----
// Port-level checker for the compositor, bound to the top level.
// Depends on the top level's ports only.
module ifc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_addr_i,
  input logic        out_we_i,
  input logic [7:0]  out_val_i,
  input logic        out_end_i
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // Keep the stalled payload steady
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_addr_i) && $stable(out_we_i) &&
      $stable(out_val_i) && $stable(out_end_i))
    else $error("result payload changed while stalled");

  // Skipped pixels carry a zero value
  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_we_i |-> out_val_i == 8'd0)
    else $error("transparent pixel with non-zero value");

  // Input backpressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a stalled output");

endmodule

bind interlaced_frame_compositor ifc_checker u_ifc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_addr_i  (res_o.canvas_address),
  .out_we_i    (res_o.write_enable),
  .out_val_i   (res_o.pixel_value),
  .out_end_i   (res_o.frame_end)
);

// ----- dv/testbench.sv -----
// Self-checking testbench for the interlaced frame compositor: palette remap, interlaced rows,
// transparency and canvas address arithmetic, with random idling on both channels.
// Depends on ifc_pkg, ifc_pix_if, ifc_res_if and the interlaced_frame_compositor design.
module testbench;
  import ifc_pkg::*;

  localparam logic        FUNC_LOAD       = 1'b0;
  localparam logic        FUNC_PIXEL      = 1'b1;
  localparam int unsigned RANDOM_BEATS    = 580;
  localparam int unsigned CALM_FROM       = 250;
  localparam int unsigned CALM_TO         = 350;
  localparam int unsigned HOLD_AT_BEAT    = 400;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned DEEP_ROWS       = 24;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  localparam logic [15:0] PASS_FIRST_ROW [4] = '{16'd0, 16'd4, 16'd2, 16'd1};
  localparam logic [15:0] PASS_ROW_STRIDE[4] = '{16'd8, 16'd8, 16'd4, 16'd2};

  typedef struct packed {
    logic       func;
    logic [7:0] map_slot;
    logic [7:0] map_target;
    logic [7:0] source_index;
    logic       frame_begin;
  } beat_t;

  typedef struct packed {
    logic [31:0] addr;
    logic        we;
    logic [7:0]  value;
    logic        fend;
  } canvas_write_t;

  // Tracks raster position and remap table, and holds the canvas writes still owed
  class canvas_write_tracker;
    cfg_t          regs;
    logic [7:0]    palette_map [256];
    logic [15:0]   col_cnt;
    logic [15:0]   rows_done;
    logic [15:0]   row_pos;
    logic [1:0]    pass_no;
    canvas_write_t expected_writes[$];
    int unsigned   errors, checked, skipped, frames, loads;

    function void restart();
      col_cnt   = '0;
      rows_done = '0;
      row_pos   = '0;
      pass_no   = '0;
    endfunction

    function void power_on();
      regs              = '0;
      regs.canvas_width = 16'd1;
      regs.frame_cols   = 16'd1;
      regs.frame_rows   = 16'd1;
      restart();
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] v);
      case (idx)
        CFG_CANVAS_WIDTH:       regs.canvas_width       = v;
        CFG_FRAME_LEFT:         regs.frame_left         = v;
        CFG_FRAME_TOP:          regs.frame_top          = v;
        CFG_FRAME_COLS:         regs.frame_cols         = v;
        CFG_FRAME_ROWS:         regs.frame_rows         = v;
        CFG_TRANSPARENT_ENABLE: regs.transparent_enable = v[0];
        CFG_TRANSPARENT_INDEX:  regs.transparent_index  = v[7:0];
        CFG_INTERLACED:         regs.interlaced         = v[0];
        default: ;
      endcase
    endfunction

    // Step to the next row: plain order wraps in 16 bits, interlaced walks the passes
    function void advance_row();
      int unsigned nxt;
      if (!regs.interlaced) begin
        row_pos = row_pos + 16'd1;
      end else begin
        nxt = int'(row_pos) + int'(PASS_ROW_STRIDE[pass_no]);
        while (nxt >= int'(regs.frame_rows)) begin
          if (pass_no == 2'd3) begin
            nxt     = 0;
            pass_no = 2'd0;
            break;
          end
          pass_no = pass_no + 2'd1;
          nxt     = int'(PASS_FIRST_ROW[pass_no]);
        end
        row_pos = nxt[15:0];
      end
    endfunction

    // Note an accepted input beat and work out the canvas write it owes
    function void take_beat(beat_t b);
      canvas_write_t w;
      logic [63:0]   full_addr;
      if (b.func == FUNC_LOAD) begin
        palette_map[b.map_slot] = b.map_target;
        loads++;
      end else begin
        if (b.frame_begin) restart();
        full_addr = (64'(regs.frame_top) + 64'(row_pos)) * 64'(regs.canvas_width)
                  + 64'(regs.frame_left) + 64'(col_cnt);
        w.addr  = full_addr[31:0];
        w.we    = !(regs.transparent_enable && b.source_index == regs.transparent_index);
        w.value = w.we ? palette_map[b.source_index] : 8'h00;
        w.fend  = 1'b0;
        if (32'(col_cnt) + 32'd1 >= 32'(regs.frame_cols)) begin
          if (32'(rows_done) + 32'd1 >= 32'(regs.frame_rows)) begin
            w.fend = 1'b1;
            restart();
          end else begin
            col_cnt   = '0;
            rows_done = rows_done + 16'd1;
            advance_row();
          end
        end else begin
          col_cnt = col_cnt + 16'd1;
        end
        expected_writes.push_back(w);
      end
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Compare one result beat with the oldest write owed
    function void match_write(canvas_write_t got);
      canvas_write_t want;
      if (expected_writes.size() == 0) begin
        errors++;
        $display("%0t: canvas write with none owed, expected nothing, actual addr %0h",
                 $time, got.addr);
      end else begin
        want = expected_writes.pop_front();
        checked++;
        if (!want.we) skipped++;
        if (want.fend) frames++;
        report_field("canvas_address", want.addr, got.addr);
        report_field("write_enable", 32'(want.we), 32'(got.we));
        report_field("pixel_value", 32'(want.value), 32'(got.value));
        report_field("frame_end", 32'(want.fend), 32'(got.fend));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  ifc_pix_if pix ();
  ifc_res_if res ();

  canvas_write_tracker tracker = new;

  bit          calm;
  bit          hold_request;
  bit          slot_loaded [256];
  logic [7:0]  loaded_slots[$];
  int unsigned random_beats;
  int unsigned settings_used;
  int unsigned cycle_count = 0;

  interlaced_frame_compositor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix.sink),
    .res_o      (res.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
      $display("testbench failed");
      $finish;
    end
  end

  // Sample both channels at the edge; a result trails its beat through the stage registers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        tracker.match_write('{res.canvas_address, res.write_enable, res.pixel_value,
                              res.frame_end});
      end
      if (pix.valid && pix.ready) begin
        tracker.take_beat('{pix.func, pix.map_slot, pix.map_target, pix.source_index,
                            pix.frame_begin});
      end
    end
  end

  // Result side: random stalls, none while calm, and one long hold-off on request
  initial begin : result_sink
    res.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      res.ready <= calm || ($urandom_range(0, 99) >= 37);
    end
  end

  // Offer one beat after a random gap and hold it until taken
  task automatic send_beat(input beat_t b);
    if (!calm) begin
      while ($urandom_range(0, 99) < 37) begin
        pix.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    pix.valid        <= 1'b1;
    pix.func         <= b.func;
    pix.map_slot     <= b.map_slot;
    pix.map_target   <= b.map_target;
    pix.source_index <= b.source_index;
    pix.frame_begin  <= b.frame_begin;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
  endtask

  task automatic send_load(input logic [7:0] slot, input logic [7:0] target);
    send_beat('{FUNC_LOAD, slot, target, 8'($urandom), 1'($urandom)});
    if (!slot_loaded[slot]) begin
      slot_loaded[slot] = 1'b1;
      loaded_slots.push_back(slot);
    end
  endtask

  task automatic send_pixel(input logic [7:0] src, input logic first);
    send_beat('{FUNC_PIXEL, 8'($urandom), 8'($urandom), src, first});
  endtask

  // Drop valid, wait for every owed write, then let any trailing load clear the stages
  task automatic settle_pipeline();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.expected_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_one(input cfg_idx_e idx, input logic [15:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    tracker.write_reg(idx, v);
  endtask

  // Write every register; unused upper data bits carry noise
  task automatic program_regs(input cfg_t c);
    write_one(CFG_CANVAS_WIDTH, c.canvas_width);
    write_one(CFG_FRAME_LEFT, c.frame_left);
    write_one(CFG_FRAME_TOP, c.frame_top);
    write_one(CFG_FRAME_COLS, c.frame_cols);
    write_one(CFG_FRAME_ROWS, c.frame_rows);
    write_one(CFG_TRANSPARENT_ENABLE, {15'($urandom), c.transparent_enable});
    write_one(CFG_TRANSPARENT_INDEX, {8'($urandom), c.transparent_index});
    write_one(CFG_INTERLACED, {15'($urandom), c.interlaced});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Only loaded entries are read; the transparent index may be anything
  function automatic logic [7:0] pick_source();
    if (tracker.regs.transparent_enable && $urandom_range(0, 99) < 20)
      return tracker.regs.transparent_index;
    return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
  endfunction

  function automatic logic [15:0] pick_dim(input int unsigned lo, input int unsigned hi);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return 16'hFFFF;
    if (roll < 14) return 16'(lo);
    return 16'($urandom_range(lo, hi));
  endfunction

  task automatic directed_checks();
    cfg_t c;
    // Reset settings: every pixel is a one-pixel frame at address zero
    send_load(8'h00, 8'hFF);
    send_load(8'hFF, 8'h00);
    send_load(8'hA5, 8'h5A);
    send_load(8'h5A, 8'hA5);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b1);
    settle_pipeline();
    // Far corner of the largest canvas, interlaced, transparent 5A; addresses wrap
    c = '{canvas_width: 16'hFFFF, frame_left: 16'hFFFF, frame_top: 16'hFFFF,
          frame_cols: 16'd2, frame_rows: 16'd3, transparent_enable: 1'b1,
          transparent_index: 8'h5A, interlaced: 1'b1};
    program_regs(c);
    send_pixel(8'hA5, 1'b1);
    send_pixel(8'h5A, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hA5, 1'b0);
    send_pixel(8'h00, 1'b0);
    settle_pipeline();
    // Shrink the frame mid-row: row and frame end on the next pixel
    c = '{canvas_width: 16'd10, frame_left: 16'd3, frame_top: 16'd1,
          frame_cols: 16'd4, frame_rows: 16'd4, transparent_enable: 1'b0,
          transparent_index: 8'h00, interlaced: 1'b0};
    program_regs(c);
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    settle_pipeline();
    c.frame_cols = 16'd1;
    c.frame_rows = 16'd1;
    program_regs(c);
    send_pixel(8'hA5, 1'b0);
    settle_pipeline();
    // Grow the frame after the last pass has started, so the passes run out early
    c.frame_rows = 16'd2;
    c.interlaced = 1'b1;
    program_regs(c);
    send_pixel(8'h5A, 1'b1);
    settle_pipeline();
    c.frame_rows = 16'd5;
    program_regs(c);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'hA5, 1'b0);
    settle_pipeline();
  endtask

  // Mostly whole frames under fresh settings, with loads, stray frame starts and carried position
  task automatic random_phases();
    cfg_t        c;
    int unsigned budget;
    int unsigned to_frame_end;
    logic        first;
    to_frame_end = 0;
    while (random_beats < RANDOM_BEATS) begin
      calm = (random_beats >= CALM_FROM && random_beats < CALM_TO);
      c.canvas_width       = pick_dim(1, 64);
      c.frame_left         = pick_dim(0, 40);
      c.frame_top          = pick_dim(0, 40);
      c.frame_cols         = pick_dim(1, 9);
      c.frame_rows         = pick_dim(1, 20);
      c.transparent_enable = 1'($urandom);
      c.transparent_index  = 8'($urandom);
      c.interlaced         = 1'($urandom);
      program_regs(c);
      if ($urandom_range(0, 99) < 80) to_frame_end = 0;
      budget = $urandom_range(15, 60);
      repeat (budget) begin
        if ($urandom_range(0, 99) < 12) begin
          send_load(8'($urandom), 8'($urandom));
        end else begin
          if (!hold_request && random_beats >= HOLD_AT_BEAT && random_beats < HOLD_AT_BEAT + 5)
            hold_request = 1'b1;
          first = (to_frame_end == 0) || ($urandom_range(0, 99) < 3);
          if (first) to_frame_end = 32'(c.frame_cols) * 32'(c.frame_rows);
          send_pixel(pick_source(), first);
          to_frame_end--;
        end
        random_beats++;
      end
      settle_pipeline();
    end
    calm = 1'b0;
  endtask

  // Walk the start of pass one of a tall interlaced frame, then carry on in plain order
  task automatic deep_row_phase();
    cfg_t c;
    c = '{canvas_width: 16'd3, frame_left: 16'd1, frame_top: 16'd2,
          frame_cols: 16'd1, frame_rows: 16'hFFFF, transparent_enable: 1'b0,
          transparent_index: 8'h00, interlaced: 1'b1};
    program_regs(c);
    for (int unsigned i = 0; i < DEEP_ROWS; i++) send_pixel(pick_source(), i == 0);
    settle_pipeline();
    c.interlaced = 1'b0;
    program_regs(c);
    repeat (10) send_pixel(pick_source(), 1'b0);
    settle_pipeline();
  endtask

  initial begin : stimulus
    tracker.power_on();
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_CANVAS_WIDTH;
    cfg_data_i       <= '0;
    pix.valid        <= 1'b0;
    pix.func         <= FUNC_LOAD;
    pix.map_slot     <= '0;
    pix.map_target   <= '0;
    pix.source_index <= '0;
    pix.frame_begin  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_checks();
    random_phases();
    deep_row_phase();
    settle_pipeline();
    if (tracker.expected_writes.size() != 0)
      $display("%0t: %0d canvas writes never arrived", $time, tracker.expected_writes.size());
    $display("Covered %0d palette loads and %0d pixel beats over %0d register settings,",
             tracker.loads, tracker.checked, settings_used);
    $display("with %0d transparent skips, %0d frames closed and %0d mismatches.",
             tracker.skipped, tracker.frames, tracker.errors);
    if (tracker.errors == 0 && tracker.expected_writes.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ifc_pkg.sv
design/ifc_pix_if.sv
design/ifc_res_if.sv
design/ifc_cfg_regs.sv
design/ifc_raster.sv
design/ifc_remap.sv
design/ifc_out_stage.sv
design/interlaced_frame_compositor.sv
design/ifc_checker.sv
dv/testbench.sv
